FILE: rtl/core/tss_pkg.sv
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared widths, defaults and types for the tridiagonal system solver.
// ----------------------------------------------------------------------------
package tss_pkg;

   // Default system depth and internal value width
   localparam int MAX_SIZE    = 16;
   localparam int VALUE_WIDTH = 32;

   // Width of every value field on the channels
   localparam int IO_WIDTH    = 32;

   // Fraction bits of the fixed-point format
   localparam int FRAC_BITS   = 16;

   typedef logic signed [IO_WIDTH-1:0] io_value_type;

endpackage

FILE: rtl/core/tss_req_if.sv
// ----------------------------------------------------------------------------
// Tridiagonal solver request channel
// Valid/ready channel that carries one right-hand-side element per
// transaction, with the coefficients sampled on the first one of a system.
// ----------------------------------------------------------------------------
interface tss_req_if;

   logic                  valid;
   logic                  ready;
   tss_pkg::io_value_type rhs_value;
   tss_pkg::io_value_type diag_middle;
   tss_pkg::io_value_type diag_end;
   tss_pkg::io_value_type off_diag;
   logic                  last_element;

   modport source (
      output valid, rhs_value, diag_middle, diag_end, off_diag, last_element,
      input  ready
   );

   modport sink (
      input  valid, rhs_value, diag_middle, diag_end, off_diag, last_element,
      output ready
   );

endinterface

FILE: rtl/core/tss_rsp_if.sv
// ----------------------------------------------------------------------------
// Tridiagonal solver response channel
// Valid/ready channel that carries one solution element per transaction.
// ----------------------------------------------------------------------------
interface tss_rsp_if;

   logic                  valid;
   logic                  ready;
   tss_pkg::io_value_type solution_value;
   logic                  solution_last;
   logic                  divide_error;

   modport source (
      output valid, solution_value, solution_last, divide_error,
      input  ready
   );

   modport sink (
      input  valid, solution_value, solution_last, divide_error,
      output ready
   );

endinterface

FILE: rtl/core/tss_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module tss_ram #(
   parameter  int WIDTH  = 2 * tss_pkg::VALUE_WIDTH,
   parameter  int DEPTH  = tss_pkg::MAX_SIZE,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tss_mul.sv
// ----------------------------------------------------------------------------
// Tridiagonal solver multiplier
// Multi-cycle signed fixed-point multiply: magnitude product built from
// 16-bit slices of the second operand, shifted by the fraction bits,
// truncated toward zero and saturated to the value range.
// ----------------------------------------------------------------------------
module tss_mul #(
   parameter int VALUE_WIDTH = tss_pkg::VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [VALUE_WIDTH-1:0] op_a,
   input  logic signed [VALUE_WIDTH-1:0] op_b,
   output logic                          done,
   output logic signed [VALUE_WIDTH-1:0] product
);

   localparam int VW      = VALUE_WIDTH;
   localparam int SLICE_W = 16;
   localparam int NCH     = (VW + SLICE_W - 1) / SLICE_W;
   localparam int BW      = NCH * SLICE_W;
   localparam int AW      = VW + BW;
   localparam int PW      = VW + SLICE_W;
   localparam int SW      = (NCH > 1) ? $clog2(NCH) : 1;
   localparam logic [AW-1:0] MAG_MAX = (AW'(1) << (VW - 1)) - AW'(1);
   localparam logic [AW-1:0] MAG_MIN = AW'(1) << (VW - 1);
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

   function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] x);
      logic [VW-1:0] r;
      r = x[VW-1] ? (~x + 1'b1) : x;
      return r;
   endfunction

   logic [VW-1:0]        ma_ff, ma_in;
   logic [BW-1:0]        mb_ff, mb_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   logic [SW-1:0]        step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic signed [VW-1:0] product_ff, product_in;
   logic [PW-1:0]        part;
   logic [AW-1:0]        shifted;

   // Partial product of one slice and the saturated result
   always_comb begin
      part    = PW'(ma_ff) * PW'(mb_ff[SLICE_W-1:0]);
      shifted = acc_ff >> tss_pkg::FRAC_BITS;
      if (neg_ff) begin
         product_in = (shifted > MAG_MIN) ? VAL_MIN : VW'(AW'(0) - shifted);
      end else begin
         product_in = (shifted > MAG_MAX) ? VAL_MAX : VW'(shifted);
      end
   end

   // Sequence: load, one slice per cycle, saturate, report
   always_comb begin
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      if (start) begin
         ma_in   = mag_of(op_a);
         mb_in   = BW'(mag_of(op_b));
         neg_in  = op_a[VW-1] ^ op_b[VW-1];
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = (acc_ff >> SLICE_W) + (AW'(part) << (AW - PW));
         mb_in   = mb_ff >> SLICE_W;
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(NCH - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      if (fin_ff) begin
         product_ff <= product_in;
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

FILE: rtl/core/tss_div.sv
// ----------------------------------------------------------------------------
// Tridiagonal solver divider
// Bit-serial restoring divide of (a * 2^16) / b on magnitudes, truncated
// toward zero and saturated; a zero divisor gives zero and a flag.
// ----------------------------------------------------------------------------
module tss_div #(
   parameter int VALUE_WIDTH = tss_pkg::VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [VALUE_WIDTH-1:0] op_a,
   input  logic signed [VALUE_WIDTH-1:0] op_b,
   output logic                          done,
   output logic signed [VALUE_WIDTH-1:0] quotient,
   output logic                          div_zero
);

   localparam int VW = VALUE_WIDTH;
   localparam int DW = VW + tss_pkg::FRAC_BITS;
   localparam int CW = $clog2(DW);
   localparam logic [DW-1:0] MAG_MAX = (DW'(1) << (VW - 1)) - DW'(1);
   localparam logic [DW-1:0] MAG_MIN = DW'(1) << (VW - 1);
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

   function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] x);
      logic [VW-1:0] r;
      r = x[VW-1] ? (~x + 1'b1) : x;
      return r;
   endfunction

   logic [VW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [VW-1:0]        mb_ff, mb_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [CW-1:0]        step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic signed [VW-1:0] quotient_ff, quotient_in;
   logic                 div_zero_ff;
   logic [VW:0]          rem_sh;
   logic [VW+1:0]        diff;

   // One restoring step and the saturated result
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DW-1]};
      diff   = {1'b0, rem_sh} - {2'b00, mb_ff};
      if (zero_ff) begin
         quotient_in = '0;
      end else if (neg_ff) begin
         quotient_in = (quo_ff > MAG_MIN) ? VAL_MIN : VW'(DW'(0) - quo_ff);
      end else begin
         quotient_in = (quo_ff > MAG_MAX) ? VAL_MAX : VW'(quo_ff);
      end
   end

   // Sequence: load, one quotient bit per cycle, saturate, report
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = DW'(mag_of(op_a)) << tss_pkg::FRAC_BITS;
         mb_in   = mag_of(op_b);
         neg_in  = op_a[VW-1] ^ op_b[VW-1];
         zero_in = (op_b == '0);
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[VW+1]) begin
            rem_in = diff[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      step_ff <= step_in;
      if (fin_ff) begin
         quotient_ff <= quotient_in;
         div_zero_ff <= zero_ff;
      end
   end

   assign done     = done_ff;
   assign quotient = quotient_ff;
   assign div_zero = div_zero_ff;

endmodule

FILE: rtl/core/tridiagonal_system_solver.sv
// ----------------------------------------------------------------------------
// Tridiagonal system solver
// Thomas algorithm on signed Q16.16 values, forward sweep per element and
// back substitution on the closing element.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus takes one right-hand-side element per transaction. The first
//   element of a system also carries the three matrix coefficients. An
//   element with last_element set, or the element that fills MAX_SIZE
//   rows, closes the system.
//   rsp_bus returns the solution in index order, one element per
//   transaction, solution_last on the final one, divide_error on all of
//   them when any pivot of the system was zero.
//   Each row is paced by the bit-serial divider, which runs twice per
//   row. The closing row runs one divide, then back substitution row by
//   row, then reads out each solution element through the single read
//   port of the row memory.
//   One element is worked on at a time; req_bus.ready is high only between
//   elements. The response register holds a result while rsp_bus stalls,
//   and the next element is accepted while the last result still waits.
//   Reset clears the element count, the error flag and both channels; the
//   row memory needs no clearing.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver #(
   parameter int MAX_SIZE    = tss_pkg::MAX_SIZE,
   parameter int VALUE_WIDTH = tss_pkg::VALUE_WIDTH
) (
   input logic      clock,
   input logic      reset,
   tss_req_if.sink  req_bus,
   tss_rsp_if.source rsp_bus
);

   localparam int VW = VALUE_WIDTH;
   localparam int MW = 2 * VW;
   localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int IO = tss_pkg::IO_WIDTH;
   localparam int EW = (VW > IO) ? VW : IO;
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_SIZE - 1);
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [EW-1:0] IN_MAX_E  = $signed({{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}});
   localparam logic signed [EW-1:0] IN_MIN_E  = ~IN_MAX_E;
   localparam logic signed [EW-1:0] OUT_MAX_E = $signed({{(EW-IO+1){1'b0}}, {(IO-1){1'b1}}});
   localparam logic signed [EW-1:0] OUT_MIN_E = ~OUT_MAX_E;

   // Sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_FW_RD     = 4'd1;
   localparam logic [3:0] S_MULU_WAIT = 4'd2;
   localparam logic [3:0] S_MULD_GO   = 4'd3;
   localparam logic [3:0] S_MULD_WAIT = 4'd4;
   localparam logic [3:0] S_DIVD_GO   = 4'd5;
   localparam logic [3:0] S_DIVD_WAIT = 4'd6;
   localparam logic [3:0] S_DIVU_GO   = 4'd7;
   localparam logic [3:0] S_DIVU_WAIT = 4'd8;
   localparam logic [3:0] S_BS_RD     = 4'd9;
   localparam logic [3:0] S_BS_MUL    = 4'd10;
   localparam logic [3:0] S_BS_WAIT   = 4'd11;
   localparam logic [3:0] S_OUT_RD    = 4'd12;
   localparam logic [3:0] S_OUT_LD    = 4'd13;

   // Saturate a channel value into the internal range
   function automatic logic signed [VW-1:0] sat_in(input tss_pkg::io_value_type x);
      logic signed [EW-1:0] e;
      e = EW'(x);
      if (e > IN_MAX_E) begin
         return VAL_MAX;
      end else if (e < IN_MIN_E) begin
         return VAL_MIN;
      end
      return VW'(e);
   endfunction

   // Saturate an internal value into the channel range
   function automatic tss_pkg::io_value_type sat_out(input logic signed [VW-1:0] x);
      logic signed [EW-1:0] e;
      e = EW'(x);
      if (e > OUT_MAX_E) begin
         return IO'(OUT_MAX_E);
      end else if (e < OUT_MIN_E) begin
         return IO'(OUT_MIN_E);
      end
      return IO'(e);
   endfunction

   // Saturating difference
   function automatic logic signed [VW-1:0] sub_sat(input logic signed [VW-1:0] a,
                                                    input logic signed [VW-1:0] b);
      logic signed [VW:0] d;
      d = (VW+1)'(a) - (VW+1)'(b);
      if (d[VW] != d[VW-1]) begin
         return d[VW] ? VAL_MIN : VAL_MAX;
      end
      return d[VW-1:0];
   endfunction

   logic [3:0]            state_ff, state_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         i_ff, i_in;
   logic [AW-1:0]         o_ff, o_in;
   logic                  closing_ff, closing_in;
   logic                  err_ff, err_in;
   logic signed [VW-1:0]  cm_ff, cm_in;
   logic signed [VW-1:0]  ce_ff, ce_in;
   logic signed [VW-1:0]  co_ff, co_in;
   logic signed [VW-1:0]  v_ff, v_in;
   logic signed [VW-1:0]  num_ff, num_in;
   logic signed [VW-1:0]  den_ff, den_in;
   logic signed [VW-1:0]  dn_ff, dn_in;
   logic signed [VW-1:0]  x_ff, x_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tss_pkg::io_value_type rsp_value_ff;
   logic                  rsp_last_ff;
   logic                  rsp_err_ff;

   logic                  req_fire;
   logic                  rsp_load;
   logic                  mul_start, mul_done;
   logic signed [VW-1:0]  mul_a, mul_b, mul_res;
   logic                  div_start, div_done, div_zero;
   logic signed [VW-1:0]  div_a, div_b, div_res;
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [MW-1:0]         wr_data, rd_data;
   logic signed [VW-1:0]  rd_upper, rd_lower;
   logic signed [VW-1:0]  in_rhs, in_dm, in_de, in_od;

   // Row memory: upper half modified super-diagonal, lower half modified
   // right-hand side, overwritten by the solution during back substitution
   tss_ram #(
      .WIDTH (MW),
      .DEPTH (MAX_SIZE)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tss_mul #(
      .VALUE_WIDTH (VW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_res)
   );

   tss_div #(
      .VALUE_WIDTH (VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .op_a     (div_a),
      .op_b     (div_b),
      .done     (div_done),
      .quotient (div_res),
      .div_zero (div_zero)
   );

   assign rd_upper = $signed(rd_data[MW-1:VW]);
   assign rd_lower = $signed(rd_data[VW-1:0]);
   assign in_rhs   = sat_in(req_bus.rhs_value);
   assign in_dm    = sat_in(req_bus.diag_middle);
   assign in_de    = sat_in(req_bus.diag_end);
   assign in_od    = sat_in(req_bus.off_diag);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_load = (state_ff == S_OUT_LD) && (!rsp_valid_ff || rsp_bus.ready);

   // Sequencer: forward sweep, back substitution, result readout
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      i_in       = i_ff;
      o_in       = o_ff;
      closing_in = closing_ff;
      err_in     = err_ff;
      cm_in      = cm_ff;
      ce_in      = ce_ff;
      co_in      = co_ff;
      v_in       = v_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      dn_in      = dn_ff;
      x_in       = x_ff;
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      div_a      = '0;
      div_b      = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               v_in       = in_rhs;
               idx_in     = cnt_ff;
               closing_in = req_bus.last_element || (cnt_ff == LAST_IDX);
               if (cnt_ff == '0) begin
                  // first row: sample coefficients, pivot is the end diagonal
                  cm_in    = in_dm;
                  ce_in    = in_de;
                  co_in    = in_od;
                  err_in   = 1'b0;
                  den_in   = in_de;
                  num_in   = in_rhs;
                  state_in = S_DIVD_GO;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = cnt_ff - 1'b1;
                  state_in = S_FW_RD;
               end
            end
         end
         S_FW_RD: begin
            mul_start = 1'b1;
            mul_a     = rd_upper;
            mul_b     = co_ff;
            state_in  = S_MULU_WAIT;
         end
         S_MULU_WAIT: begin
            if (mul_done) begin
               den_in   = sub_sat(closing_ff ? ce_ff : cm_ff, mul_res);
               state_in = S_MULD_GO;
            end
         end
         S_MULD_GO: begin
            mul_start = 1'b1;
            mul_a     = co_ff;
            mul_b     = rd_lower;
            state_in  = S_MULD_WAIT;
         end
         S_MULD_WAIT: begin
            if (mul_done) begin
               num_in   = sub_sat(v_ff, mul_res);
               state_in = S_DIVD_GO;
            end
         end
         S_DIVD_GO: begin
            div_start = 1'b1;
            div_a     = num_ff;
            div_b     = den_ff;
            state_in  = S_DIVD_WAIT;
         end
         S_DIVD_WAIT: begin
            if (div_done) begin
               dn_in = div_res;
               if (div_zero) begin
                  err_in = 1'b1;
               end
               if (closing_ff) begin
                  // last row: its value is the last solution element
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff;
                  wr_data  = {{VW{1'b0}}, div_res};
                  x_in     = div_res;
                  i_in     = idx_ff;
                  state_in = S_BS_RD;
               end else begin
                  state_in = S_DIVU_GO;
               end
            end
         end
         S_DIVU_GO: begin
            div_start = 1'b1;
            div_a     = co_ff;
            div_b     = den_ff;
            state_in  = S_DIVU_WAIT;
         end
         S_DIVU_WAIT: begin
            if (div_done) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = {div_res, dn_ff};
               if (div_zero) begin
                  err_in = 1'b1;
               end
               cnt_in   = idx_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         S_BS_RD: begin
            if (i_ff == '0) begin
               o_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = i_ff - 1'b1;
               state_in = S_BS_MUL;
            end
         end
         S_BS_MUL: begin
            mul_start = 1'b1;
            mul_a     = rd_upper;
            mul_b     = x_ff;
            state_in  = S_BS_WAIT;
         end
         S_BS_WAIT: begin
            if (mul_done) begin
               x_in     = sub_sat(rd_lower, mul_res);
               wr_en    = 1'b1;
               wr_addr  = i_ff - 1'b1;
               wr_data  = {rd_upper, x_in};
               i_in     = i_ff - 1'b1;
               state_in = S_BS_RD;
            end
         end
         S_OUT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = o_ff;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            if (rsp_load) begin
               if (o_ff == idx_ff) begin
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  o_in     = o_ff + 1'b1;
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register: load a result, drop it once taken
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      i_ff       <= i_in;
      o_ff       <= o_in;
      closing_ff <= closing_in;
      cm_ff      <= cm_in;
      ce_ff      <= ce_in;
      co_ff      <= co_in;
      v_ff       <= v_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      dn_ff      <= dn_in;
      x_ff       <= x_in;
      if (rsp_load) begin
         rsp_value_ff <= sat_out(rd_lower);
         rsp_last_ff  <= (o_ff == idx_ff);
         rsp_err_ff   <= err_ff;
      end
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.solution_value = rsp_value_ff;
   assign rsp_bus.solution_last  = rsp_last_ff;
   assign rsp_bus.divide_error   = rsp_err_ff;

endmodule
